// ----- rtl/mf3_pkg.sv -----
`timescale 1ns / 1ps

package mf3_pkg;

  // Configuration register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  localparam int CFG_W = 12;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd1080;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd1920;

  // Smallest frame dimension the filter works on
  localparam logic [CFG_W-1:0] MIN_DIM = 12'd3;

  // Window geometry and the rank that is the median (fifth smallest)
  localparam int WIN_TAPS    = 9;
  localparam int MEDIAN_RANK = 5;

  // Per-transaction flags that travel with a pixel down the pipeline
  typedef struct packed {
    logic res;  // window is interior, a result is produced
    logic eol;  // last result of an output line
    logic eof;  // last result of the output frame
  } mf3_tag_t;

endpackage

// ----- rtl/mf3_line_buffer.sv -----
`timescale 1ns / 1ps

module mf3_line_buffer #(
  parameter int DEPTH = 2048,
  parameter int PIX_W = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [PIX_W-1:0] pix_i,
  output logic [PIX_W-1:0] up_o,
  output logic [PIX_W-1:0] mid_o,
  output logic [PIX_W-1:0] pix_o
);

  // Two line stores: two lines above and one line above the current pixel
  logic [PIX_W-1:0] upper_mem  [DEPTH];
  logic [PIX_W-1:0] middle_mem [DEPTH];

  logic [PIX_W-1:0] up_rd_q, mid_rd_q;
  logic [PIX_W-1:0] fwd_up_q, fwd_mid_q;
  logic [PIX_W-1:0] pix_q;
  logic [AW-1:0]    addr_q;
  logic             wr_pend_q;
  logic             fwd_q;

  // Column data seen by the pipeline, with bypass of a same-cycle write
  assign up_o  = fwd_q ? fwd_up_q  : up_rd_q;
  assign mid_o = fwd_q ? fwd_mid_q : mid_rd_q;
  assign pix_o = pix_q;

  // Write back in the cycle after the read: middle moves up, new pixel enters middle
  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      upper_mem[addr_q]  <= mid_o;
      middle_mem[addr_q] <= pix_q;
    end
    if (rd_en_i) begin
      up_rd_q   <= upper_mem[addr_i];
      mid_rd_q  <= middle_mem[addr_i];
      addr_q    <= addr_i;
      pix_q     <= pix_i;
      fwd_up_q  <= mid_o;
      fwd_mid_q <= pix_q;
    end
  end

  // Pending write and bypass select
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      wr_pend_q <= rd_en_i;
      if (rd_en_i) begin
        fwd_q <= wr_pend_q && (addr_i == addr_q);
      end
    end
  end

endmodule

// ----- rtl/mf3_window.sv -----
`timescale 1ns / 1ps

module mf3_window #(
  parameter int PIX_W = 8
) (
  input  logic                            clk_i,
  input  logic                            shift_i,
  input  logic [PIX_W-1:0]                up_i,
  input  logic [PIX_W-1:0]                mid_i,
  input  logic [PIX_W-1:0]                pix_i,
  input  mf3_pkg::mf3_tag_t               tag_i,
  output logic [mf3_pkg::WIN_TAPS-1:0][PIX_W-1:0] win_o,
  output mf3_pkg::mf3_tag_t               tag_o
);

  import mf3_pkg::*;

  // Taps are [row*3+col]; row 0 is top, col 2 is the newest column
  logic [WIN_TAPS-1:0][PIX_W-1:0] win_q;
  mf3_tag_t                       tag_q;

  assign win_o = win_q;
  assign tag_o = tag_q;

  // Shift the window left one column and load the new column
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= up_i;
      win_q[5] <= mid_i;
      win_q[8] <= pix_i;
      tag_q    <= tag_i;
    end
  end

endmodule

// ----- rtl/mf3_median.sv -----
`timescale 1ns / 1ps

module mf3_median #(
  parameter int PIX_W = 8
) (
  input  logic [mf3_pkg::WIN_TAPS-1:0][PIX_W-1:0] win_i,
  output logic [PIX_W-1:0]                         med_o
);

  import mf3_pkg::*;

  logic [3:0] rank [WIN_TAPS];

  // Rank every tap (ties broken by position), then pick the one at the median rank
  always_comb begin
    med_o = '0;
    for (int i = 0; i < WIN_TAPS; i++) begin
      rank[i] = 4'd0;
      for (int j = 0; j < WIN_TAPS; j++) begin
        if (j != i) begin
          if ((win_i[j] < win_i[i]) || ((j < i) && (win_i[j] == win_i[i]))) begin
            rank[i] = rank[i] + 4'd1;
          end
        end
      end
    end
    for (int i = 0; i < WIN_TAPS; i++) begin
      if (rank[i] == 4'(MEDIAN_RANK - 1)) begin
        med_o = win_i[i];
      end
    end
  end

endmodule

// ----- rtl/median_filter_3x3.sv -----
`timescale 1ns / 1ps

// 3x3 median filter for a raster-order grayscale stream. One pixel is taken
// per clock and one result per clock can leave while no stall holds the
// pipeline; a result passes the line store read, the window shift and the
// median rank-and-select into the output register. Results exist only
// for interior pixels, so the output frame is (frame_width-2) x
// (frame_height-2), each line tagged end_of_line and the last one
// end_of_frame. start_of_frame restarts the position counters; a frame also
// wraps on its own after its last pixel. The two line stores are MAX_WIDTH
// deep single-port-write memories that need no clearing after reset.
// frame_width and frame_height may only be changed while the block is idle.

module median_filter_3x3 #(
  parameter int MAX_WIDTH  = 2048,
  parameter int PIXEL_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // pixel input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [PIXEL_BITS-1:0]       pixel_i,
  input  logic                        start_of_frame_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [PIXEL_BITS-1:0]       median_pixel_o,
  output logic                        end_of_line_o,
  output logic                        end_of_frame_o,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [mf3_pkg::CFG_W-1:0]   cfg_data_i
);

  import mf3_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CW    = (COL_W > CFG_W) ? COL_W + 1 : CFG_W + 1;

  // Configuration registers
  logic [CFG_W-1:0] frame_width_q, frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Last column and last row after clamping to the supported range
  logic [CW-1:0]    width_ext, width_eff, col_last;
  logic [CFG_W-1:0] height_eff, row_last;

  always_comb begin
    width_ext = CW'(frame_width_q);
    if (width_ext < CW'(MIN_DIM)) begin
      width_eff = CW'(MIN_DIM);
    end else if (width_ext > CW'(MAX_WIDTH)) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    col_last   = width_eff - CW'(1);
    height_eff = (frame_height_q < MIN_DIM) ? MIN_DIM : frame_height_q;
    row_last   = height_eff - CFG_W'(1);
  end

  // Pipeline handshake: each stage moves when the next one is free
  logic accept;
  logic s1_v_q, s2_v_q, out_v_q;
  logic out_free, s2_free, s1_free, s2_adv, s1_adv;
  mf3_tag_t s1_tag_q, s2_tag;

  assign out_free   = !out_v_q || !out_stall_i;
  assign s2_adv     = s2_v_q && out_free;
  assign s2_free    = !s2_v_q || out_free;
  assign s1_adv     = s1_v_q && s2_free;
  assign s1_free    = !s1_v_q || s2_free;
  assign in_stall_o = !s1_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Position counters
  logic [COL_W-1:0] col_q, cur_col;
  logic [CFG_W-1:0] row_q, cur_row;
  logic             last_col, last_row;
  mf3_tag_t         in_tag;

  always_comb begin
    cur_col    = start_of_frame_i ? '0 : col_q;
    cur_row    = start_of_frame_i ? '0 : row_q;
    last_col   = CW'(cur_col) >= col_last;
    last_row   = cur_row >= row_last;
    in_tag.res = (CW'(cur_col) >= CW'(2)) && (cur_row >= CFG_W'(2));
    in_tag.eol = last_col;
    in_tag.eof = last_col && last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : cur_row + CFG_W'(1);
      end else begin
        col_q <= cur_col + COL_W'(1);
        row_q <= cur_row;
      end
    end
  end

  // Stage 1: line store read
  logic [PIXEL_BITS-1:0] lb_up, lb_mid, lb_pix;

  mf3_line_buffer #(
    .DEPTH (MAX_WIDTH),
    .PIX_W (PIXEL_BITS)
  ) u_line_buffer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (accept),
    .addr_i  (cur_col),
    .pix_i   (pixel_i),
    .up_o    (lb_up),
    .mid_o   (lb_mid),
    .pix_o   (lb_pix)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_tag_q <= in_tag;
    end
  end

  // Stage 2: 3x3 window
  logic [WIN_TAPS-1:0][PIXEL_BITS-1:0] win;
  logic [PIXEL_BITS-1:0]               med;

  mf3_window #(
    .PIX_W (PIXEL_BITS)
  ) u_window (
    .clk_i   (clk_i),
    .shift_i (s1_adv),
    .up_i    (lb_up),
    .mid_i   (lb_mid),
    .pix_i   (lb_pix),
    .tag_i   (s1_tag_q),
    .win_o   (win),
    .tag_o   (s2_tag)
  );

  mf3_median #(
    .PIX_W (PIXEL_BITS)
  ) u_median (
    .win_i (win),
    .med_o (med)
  );

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_q <= 1'b1;
      end else if (s2_adv) begin
        s2_v_q <= 1'b0;
      end
      if (out_free) begin
        out_v_q <= s2_adv && s2_tag.res;
      end
    end
  end

  // Output register
  logic [PIXEL_BITS-1:0] med_q;
  logic                  eol_q, eof_q;

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      med_q <= med;
      eol_q <= s2_tag.eol;
      eof_q <= s2_tag.eof;
    end
  end

  assign out_valid_o    = out_v_q;
  assign median_pixel_o = med_q;
  assign end_of_line_o  = eol_q;
  assign end_of_frame_o = eof_q;

endmodule
